// ===== rtl/array_list_table_engine_unit_assert.svh =====
// Assertion macros for the checker in rtl/alte_checker.sv.
`ifndef ARRAY_LIST_TABLE_ENGINE_UNIT_ASSERT_SVH
`define ARRAY_LIST_TABLE_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ALTE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ALTE_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Delayed implication; the dly argument sets the delay.
`define ALTE_ASSERT_DLY(label, ante, dly, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

// ===== rtl/alte_pkg.sv =====
package alte_pkg;

	localparam int CAPACITY   = 64;
	localparam int WORD_WIDTH = 32;

	localparam int OPCODE_W = 3;
	localparam int POS_W    = 7;
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 7;
	localparam int MAXLEN_W = 7;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = MAXLEN_W'(64);

	typedef enum logic [OPCODE_W-1:0] {
		OP_APPEND    = 3'd0,
		OP_INSERT    = 3'd1,
		OP_DELETE    = 3'd2,
		OP_SEARCH    = 3'd3,
		OP_TRANSPOSE = 3'd4,
		OP_FRONT     = 3'd5,
		OP_DUMP      = 3'd6
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DUMP
	} state_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_APPEND,
		ACT_INSERT,
		ACT_DELETE,
		ACT_TRANSPOSE,
		ACT_FRONT,
		ACT_ROTATE
	} cell_act_t;

	typedef struct packed {
		cell_act_t             act;
		logic [CMP_W-1:0]      pos;
		logic [CNT_W-1:0]      fill;
		logic [WORD_WIDTH-1:0] key;
	} cell_cmd_t;

	// Cut a signed 32-bit operand to the stored word width.
	function automatic logic [WORD_WIDTH-1:0] to_word(input logic [VALUE_W-1:0] v);
		logic [63:0] ext;
		ext = 64'(signed'(v));
		return ext[WORD_WIDTH-1:0];
	endfunction

	// Sign-extend a stored word and cut it to the 32-bit result.
	function automatic logic [VALUE_W-1:0] to_result(input logic [WORD_WIDTH-1:0] w);
		logic [63:0] ext;
		ext = 64'(signed'(w));
		return ext[VALUE_W-1:0];
	endfunction

endpackage

// ===== rtl/array_list_table_engine_unit.sv =====
// Append, insert, delete: result in the cycle after acceptance; busy stays low, one per cycle.
// Search (all three forms): busy for one cycle; result taken from the registered matches.
// Dump of n entries: busy throughout, n results on consecutive cycles; the dump state
// emits the head word and rotates the live part of the cell row by one for each result.
// Reset clears the list length to zero and max_length to 64; the receiver cannot stall.
module array_list_table_engine_unit
	import alte_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [OPCODE_W-1:0]        opcode,
	input  logic [POS_W-1:0]           position,
	input  logic signed [VALUE_W-1:0]  operand_value,
	input  logic                       cfg_we,
	input  logic [MAXLEN_W-1:0]        cfg_wdata,
	output logic                       result_strobe,
	output logic                       status,
	output logic signed [VALUE_W-1:0]  result_value,
	output logic [COUNT_W-1:0]         count_after,
	output logic                       last
);

	// Control state
	state_t                state_q, state_nxt;
	logic [CNT_W-1:0]      fill_q, fill_nxt;
	logic [MAXLEN_W-1:0]   max_len_q;
	logic [IDX_W-1:0]      dump_idx_q, dump_idx_nxt;

	// Search stage: key, opcode and match vector captured at acceptance
	logic [WORD_WIDTH-1:0] key_s1;
	opcode_t               op_s1;
	logic [CAPACITY-1:0]   hits_s1;

	// Result register
	logic                  strobe_q, strobe_nxt;
	logic                  status_q, status_nxt;
	logic [VALUE_W-1:0]    value_q, value_nxt;
	logic [COUNT_W-1:0]    count_q;
	logic                  last_q, last_nxt;

	// Cell row
	cell_cmd_t             cmd;
	logic [WORD_WIDTH-1:0] words [CAPACITY];
	logic [CAPACITY-1:0]   match;
	logic [CAPACITY-1:0]   hit_low;
	logic                  found;

	logic [WORD_WIDTH-1:0] key_in;
	logic [CMP_W-1:0]      pos_w;
	logic [CMP_W-1:0]      fill_w;
	logic [CMP_W-1:0]      lim_w;
	logic                  full;
	logic                  accept;
	logic                  dump_last;

	assign key_in  = to_word(operand_value);
	assign pos_w   = CMP_W'(position);
	assign fill_w  = CMP_W'(fill_q);
	// The length limit is max_length, capped at the row's capacity.
	assign lim_w   = (CMP_W'(max_len_q) < CMP_W'(CAPACITY)) ? CMP_W'(max_len_q)
	                                                        : CMP_W'(CAPACITY);
	assign full    = fill_w >= lim_w;
	assign accept  = start && (state_q == ST_IDLE);
	assign busy    = (state_q != ST_IDLE);

	// Isolate the lowest matching cell: a search acts on the first equal word.
	assign hit_low = hits_s1 & (~hits_s1 + CAPACITY'(1));
	assign found   = |hits_s1;

	assign dump_last = (CNT_W'(dump_idx_q) + CNT_W'(1)) == fill_q;

	// Next state, cell command and result
	always_comb begin
		state_nxt    = state_q;
		fill_nxt     = fill_q;
		dump_idx_nxt = dump_idx_q;
		cmd.act      = ACT_NONE;
		cmd.pos      = pos_w;
		cmd.fill     = fill_q;
		cmd.key      = (state_q == ST_IDLE) ? key_in : key_s1;
		strobe_nxt   = 1'b0;
		status_nxt   = 1'b0;
		value_nxt    = '0;
		last_nxt     = 1'b1;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (opcode)
						OP_APPEND: begin
							strobe_nxt = 1'b1;
							if (full) begin
								status_nxt = 1'b1;
							end else begin
								cmd.act  = ACT_APPEND;
								fill_nxt = fill_q + CNT_W'(1);
							end
						end
						OP_INSERT: begin
							strobe_nxt = 1'b1;
							if (full || pos_w > fill_w) begin
								status_nxt = 1'b1;
							end else begin
								cmd.act  = ACT_INSERT;
								fill_nxt = fill_q + CNT_W'(1);
							end
						end
						OP_DELETE: begin
							strobe_nxt = 1'b1;
							if (pos_w >= fill_w) begin
								status_nxt = 1'b1;
							end else begin
								// Return the removed word, close the gap.
								cmd.act   = ACT_DELETE;
								value_nxt = to_result(words[pos_w[IDX_W-1:0]]);
								fill_nxt  = fill_q - CNT_W'(1);
							end
						end
						OP_SEARCH, OP_TRANSPOSE, OP_FRONT: begin
							// Match vector is captured now; act on it next cycle.
							state_nxt = ST_SEARCH;
						end
						OP_DUMP: begin
							if (fill_q == '0) begin
								strobe_nxt = 1'b1;
								status_nxt = 1'b1;
							end else begin
								state_nxt    = ST_DUMP;
								dump_idx_nxt = '0;
							end
						end
						default: begin
							// Unused opcode: reject, touch nothing.
							strobe_nxt = 1'b1;
							status_nxt = 1'b1;
						end
					endcase
				end
			end
			ST_SEARCH: begin
				strobe_nxt = 1'b1;
				status_nxt = !found;
				if (found && op_s1 == OP_TRANSPOSE) cmd.act = ACT_TRANSPOSE;
				else if (found && op_s1 == OP_FRONT) cmd.act = ACT_FRONT;
				state_nxt = ST_IDLE;
			end
			ST_DUMP: begin
				// Emit the head word and rotate the live part of the row by one;
				// after fill_q steps the list is back in its original order.
				strobe_nxt   = 1'b1;
				value_nxt    = to_result(words[0]);
				last_nxt     = dump_last;
				cmd.act      = ACT_ROTATE;
				dump_idx_nxt = dump_idx_q + IDX_W'(1);
				if (dump_last) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Row of storage cells, one word each, linked to both neighbors
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [WORD_WIDTH-1:0] left_w;
		logic [WORD_WIDTH-1:0] right_w;
		logic                  hit_nx;

		if (g == 0) begin : g_head
			assign left_w = words[0];
		end else begin : g_body
			assign left_w = words[g-1];
		end

		if (g == CAPACITY - 1) begin : g_tail
			assign right_w = words[g];
			assign hit_nx  = 1'b0;
		end else begin : g_inner
			assign right_w = words[g+1];
			assign hit_nx  = hit_low[g+1];
		end

		alte_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.cell_index (IDX_W'(g)),
			.left_word  (left_w),
			.right_word (right_w),
			.first_word (words[0]),
			.hit_here   (hit_low[g]),
			.hit_next   (hit_nx),
			.word       (words[g]),
			.match      (match[g])
		);
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			max_len_q  <= MAXLEN_RESET;
			dump_idx_q <= '0;
			strobe_q   <= 1'b0;
		end else begin
			state_q    <= state_nxt;
			fill_q     <= fill_nxt;
			dump_idx_q <= dump_idx_nxt;
			strobe_q   <= strobe_nxt;
			if (cfg_we) max_len_q <= cfg_wdata;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			key_s1  <= key_in;
			op_s1   <= opcode_t'(opcode);
			hits_s1 <= match;
		end
		status_q <= status_nxt;
		value_q  <= value_nxt;
		count_q  <= COUNT_W'(fill_nxt);
		last_q   <= last_nxt;
	end

	assign result_strobe = strobe_q;
	assign status        = status_q;
	assign result_value  = value_q;
	assign count_after   = count_q;
	assign last          = last_q;

endmodule

// ===== rtl/alte_cell.sv =====
module alte_cell
	import alte_pkg::*;
(
	input  logic                  clk,
	input  cell_cmd_t             cmd,
	input  logic [IDX_W-1:0]      cell_index,
	input  logic [WORD_WIDTH-1:0] left_word,
	input  logic [WORD_WIDTH-1:0] right_word,
	input  logic [WORD_WIDTH-1:0] first_word,
	input  logic                  hit_here,
	input  logic                  hit_next,
	output logic [WORD_WIDTH-1:0] word,
	output logic                  match
);

	logic [WORD_WIDTH-1:0] word_q;
	logic [WORD_WIDTH-1:0] word_nxt;
	logic [CMP_W-1:0]      idx_w;
	logic [CMP_W-1:0]      idx_inc;
	logic [CMP_W-1:0]      fill_w;

	assign idx_w   = CMP_W'(cell_index);
	assign idx_inc = idx_w + CMP_W'(1);
	assign fill_w  = CMP_W'(cmd.fill);
	assign word    = word_q;
	assign match   = (word_q == cmd.key) && (idx_w < fill_w);

	always_comb begin
		word_nxt = word_q;
		case (cmd.act)
			ACT_APPEND: begin
				if (idx_w == fill_w) word_nxt = cmd.key;
			end
			ACT_INSERT: begin
				if (idx_w > cmd.pos) word_nxt = left_word;
				else if (idx_w == cmd.pos) word_nxt = cmd.key;
			end
			ACT_DELETE: begin
				if (idx_w >= cmd.pos) word_nxt = right_word;
			end
			ACT_TRANSPOSE: begin
				if (hit_next) word_nxt = cmd.key;
				else if (hit_here && idx_w != '0) word_nxt = left_word;
			end
			ACT_FRONT: begin
				if (idx_w == '0) word_nxt = cmd.key;
				else if (hit_here) word_nxt = first_word;
			end
			ACT_ROTATE: begin
				if (idx_inc < fill_w) word_nxt = right_word;
				else if (idx_inc == fill_w) word_nxt = first_word;
			end
			default: begin
				word_nxt = word_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		word_q <= word_nxt;
	end

endmodule

// ===== rtl/alte_checker.sv =====
`include "array_list_table_engine_unit_assert.svh"

module alte_checker
	import alte_pkg::*;
(
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic [OPCODE_W-1:0]        opcode,
	input logic                       result_strobe,
	input logic                       status,
	input logic signed [VALUE_W-1:0]  result_value,
	input logic                       last
);

	logic acc;
	logic acc_edit;
	logic acc_search;

	assign acc        = start && !busy;
	assign acc_edit   = acc && (opcode == OP_APPEND || opcode == OP_INSERT ||
	                            opcode == OP_DELETE);
	assign acc_search = acc && (opcode == OP_SEARCH || opcode == OP_TRANSPOSE ||
	                            opcode == OP_FRONT);

	`ALTE_ASSERT_IMP(a_reject_zero, result_strobe && status, result_value == '0, "reject word")
	`ALTE_ASSERT_NXT(a_edit_result, acc_edit, result_strobe && last, "edit result missing")
	`ALTE_ASSERT_DLY(a_search_result, acc_search, 2, result_strobe && last && !busy, "search")
	`ALTE_ASSERT_NXT(a_dump_burst, result_strobe && !last, result_strobe, "dump burst broken")

endmodule

bind array_list_table_engine_unit alte_checker u_alte_checker (.*);

// ===== tb/array_list_table_engine_unit_tb.sv =====
`timescale 1ns / 100ps

module array_list_table_engine_unit_tb;
	import alte_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SHOWN_MISMATCHES = 50;

	// The opcode field has one code left over; the block must answer it with a reject.
	localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;

	// One expected result of the block, in the shape of its result ports.
	typedef struct {
		logic                      status;
		logic signed [VALUE_W-1:0] value;
		logic [COUNT_W-1:0]        count;
		logic                      last;
	} list_outcome_t;

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic [OPCODE_W-1:0]        opcode;
	logic [POS_W-1:0]           position;
	logic signed [VALUE_W-1:0]  operand_value;
	logic                       cfg_we;
	logic [MAXLEN_W-1:0]        cfg_wdata;
	logic                       result_strobe;
	logic                       status;
	logic signed [VALUE_W-1:0]  result_value;
	logic [COUNT_W-1:0]         count_after;
	logic                       last;

	// Shadow copy of the list, its length and the length limit register.
	logic signed [WORD_WIDTH-1:0] list_words [CAPACITY];
	int                           list_len;
	int                           len_cap;

	// Results still owed by the block, oldest first.
	list_outcome_t awaited_outcomes [$];

	int error_count;
	int items_sent;
	int results_checked;
	int dump_words;
	int cfg_writes;
	int cycle_count;

	array_list_table_engine_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.position      (position),
		.operand_value (operand_value),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.result_strobe (result_strobe),
		.status        (status),
		.result_value  (result_value),
		.count_after   (count_after),
		.last          (last)
	);

	always #5 clk = ~clk;

	// Bound the run; a hung handshake or a lost result ends up here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles, %0d results still owed",
				cycle_count, awaited_outcomes.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Print one line per mismatch (up to a cap, to keep a broken run readable) and count it.
	task automatic flag_mismatch(input string what);
		error_count++;
		if (error_count <= SHOWN_MISMATCHES)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	// Record one expected result; count_after is always the length after the operation.
	function automatic void queue_outcome(input logic st, input logic signed [VALUE_W-1:0] val,
			input logic lst);
		list_outcome_t o;
		o.status = st;
		o.value  = val;
		o.count  = COUNT_W'(list_len);
		o.last   = lst;
		awaited_outcomes.push_back(o);
	endfunction

	// Apply one accepted transaction to the shadow list and queue what the block owes for it.
	function automatic void apply_list_op(input logic [OPCODE_W-1:0] op,
			input logic [POS_W-1:0] pos, input logic signed [VALUE_W-1:0] val);
		logic signed [WORD_WIDTH-1:0] word;
		logic signed [WORD_WIDTH-1:0] held;
		int lim;
		int p;
		int hit;
		word = WORD_WIDTH'(val);
		// A register value above the capacity still stops at the capacity.
		lim  = (len_cap < CAPACITY) ? len_cap : CAPACITY;
		p    = pos;
		hit  = -1;
		case (op)
			OP_APPEND: begin
				if (list_len >= lim) begin
					queue_outcome(1'b1, '0, 1'b1);
				end else begin
					list_words[list_len] = word;
					list_len++;
					queue_outcome(1'b0, '0, 1'b1);
				end
			end
			OP_INSERT: begin
				// Reject when full, or when the slot lies past the end of the list.
				if (list_len >= lim || p > list_len) begin
					queue_outcome(1'b1, '0, 1'b1);
				end else begin
					for (int i = list_len; i > p; i--)
						list_words[i] = list_words[i - 1];
					list_words[p] = word;
					list_len++;
					queue_outcome(1'b0, '0, 1'b1);
				end
			end
			OP_DELETE: begin
				if (p >= list_len) begin
					queue_outcome(1'b1, '0, 1'b1);
				end else begin
					held = list_words[p];
					for (int i = p; i + 1 < list_len; i++)
						list_words[i] = list_words[i + 1];
					list_len--;
					queue_outcome(1'b0, VALUE_W'(held), 1'b1);
				end
			end
			OP_SEARCH, OP_TRANSPOSE, OP_FRONT: begin
				// Take the lowest matching index when words repeat.
				for (int i = 0; i < list_len; i++)
					if (hit < 0 && list_words[i] == word)
						hit = i;
				if (hit < 0) begin
					queue_outcome(1'b1, '0, 1'b1);
				end else begin
					// Transpose at the head has no predecessor: leave the list as it is.
					if (op == OP_TRANSPOSE && hit > 0) begin
						held                = list_words[hit];
						list_words[hit]     = list_words[hit - 1];
						list_words[hit - 1] = held;
					end else if (op == OP_FRONT) begin
						held            = list_words[hit];
						list_words[hit] = list_words[0];
						list_words[0]   = held;
					end
					queue_outcome(1'b0, '0, 1'b1);
				end
			end
			OP_DUMP: begin
				// An empty list still answers once, with a reject.
				if (list_len == 0) begin
					queue_outcome(1'b1, '0, 1'b1);
				end else begin
					for (int i = 0; i < list_len; i++) begin
						queue_outcome(1'b0, VALUE_W'(list_words[i]), i == list_len - 1);
						dump_words++;
					end
				end
			end
			default: begin
				queue_outcome(1'b1, '0, 1'b1);
			end
		endcase
	endfunction

	// Present one transaction and hold it until the block takes it.
	task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic signed [VALUE_W-1:0] val);
		start         <= 1'b1;
		opcode        <= op;
		position      <= pos;
		operand_value <= val;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		apply_list_op(op, pos, val);
		items_sent++;
	endtask

	// Drop start for the given number of cycles.
	task automatic pause_sender(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Drop start and wait until every owed result has come back, then let the block settle.
	task automatic drain_results();
		start <= 1'b0;
		while (awaited_outcomes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write the length limit; only called while the block is idle.
	task automatic write_max_length(input logic [MAXLEN_W-1:0] v);
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(posedge clk);
		len_cap = v;
		cfg_we  <= 1'b0;
		cfg_writes++;
	endtask

	// Pick the next random transaction, biased toward ones that do real work on the list.
	task automatic next_random_item(output logic [OPCODE_W-1:0] op,
			output logic [POS_W-1:0] pos, output logic signed [VALUE_W-1:0] val);
		logic signed [VALUE_W-1:0] corner_vals [4];
		int roll;
		corner_vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, -32'sh1};
		roll = $urandom_range(0, 99);
		if (roll < 22)
			op = OP_APPEND;
		else if (roll < 40)
			op = OP_INSERT;
		else if (roll < 58)
			op = OP_DELETE;
		else if (roll < 68)
			op = OP_SEARCH;
		else if (roll < 78)
			op = OP_TRANSPOSE;
		else if (roll < 88)
			op = OP_FRONT;
		else if (roll < 94)
			op = OP_DUMP;
		else
			op = OPCODE_W'($urandom_range(0, 7));

		// Mostly legal slots, some anywhere in the field.
		pos = POS_W'($urandom_range(0, 127));
		if (op == OP_INSERT && $urandom_range(0, 99) < 85)
			pos = POS_W'($urandom_range(0, list_len));
		else if (op == OP_DELETE && list_len > 0 && $urandom_range(0, 99) < 85)
			pos = POS_W'($urandom_range(0, list_len - 1));

		// Small values make repeats; search keys mostly come from the list itself.
		roll = $urandom_range(0, 99);
		if (roll < 60)
			val = $urandom;
		else if (roll < 80)
			val = $urandom_range(0, 7);
		else
			val = corner_vals[$urandom_range(0, 3)];
		if ((op == OP_SEARCH || op == OP_TRANSPOSE || op == OP_FRONT) && list_len > 0
				&& $urandom_range(0, 3) != 0)
			val = VALUE_W'(list_words[$urandom_range(0, list_len - 1)]);
	endtask

	// Compare every strobed result with the oldest expectation, field by field.
	always @(posedge clk) begin
		list_outcome_t want;
		if (arst_n && result_strobe === 1'b1) begin
			results_checked++;
			if (awaited_outcomes.size() == 0) begin
				flag_mismatch("result strobed with nothing owed");
			end else begin
				want = awaited_outcomes.pop_front();
				if (status !== want.status)
					flag_mismatch($sformatf("status %b, want %b", status, want.status));
				if (result_value !== want.value)
					flag_mismatch($sformatf("result_value %h, want %h",
						result_value, want.value));
				if (count_after !== want.count)
					flag_mismatch($sformatf("count_after %0d, want %0d",
						count_after, want.count));
				if (last !== want.last)
					flag_mismatch($sformatf("last %b, want %b", last, want.last));
			end
		end
	end

	// Dump, delete, search, transpose and an unused opcode against a list that has never held anything.
	task automatic test_empty_list();
		send_item(OP_DUMP, '0, '0);
		send_item(OP_DELETE, '0, '0);
		send_item(OP_SEARCH, '0, '0);
		send_item(OP_TRANSPOSE, '0, -32'sh1);
		send_item(OP_UNUSED, 7'd127, 32'sh8000_0000);
	endtask

	// Each operation once or more, with extreme words, repeats and bad slots.
	task automatic test_basic_ops();
		send_item(OP_APPEND, '0, 32'sh7FFF_FFFF);
		send_item(OP_APPEND, '0, 32'sh8000_0000);
		send_item(OP_APPEND, '0, 32'sh0);
		send_item(OP_APPEND, '0, -32'sh1);
		send_item(OP_INSERT, 7'd0, 32'sd5);
		// insert right at the end, making a repeated word
		send_item(OP_INSERT, 7'd5, 32'sd5);
		send_item(OP_INSERT, 7'd7, 32'sd9);
		send_item(OP_INSERT, 7'd127, 32'sd9);
		send_item(OP_SEARCH, '0, 32'sd5);
		// hit at the head: no swap
		send_item(OP_TRANSPOSE, '0, 32'sd5);
		send_item(OP_TRANSPOSE, '0, 32'sh0);
		send_item(OP_FRONT, '0, -32'sh1);
		send_item(OP_SEARCH, '0, 32'sd12345);
		send_item(OP_FRONT, '0, 32'sd12345);
		send_item(OP_DUMP, '0, '0);
		send_item(OP_DELETE, 7'd0, '0);
		send_item(OP_DELETE, 7'd4, '0);
		send_item(OP_DELETE, 7'd127, '0);
		send_item(OP_DELETE, 7'd4, '0);
		send_item(OP_UNUSED, 7'd127, -32'sh1);
		send_item(OP_DUMP, '0, '0);
	endtask

	// Length limit at zero, at one, and above the capacity with the list filled to the brim.
	task automatic test_length_limit();
		drain_results();
		write_max_length(7'd0);
		send_item(OP_APPEND, '0, 32'sd1);
		send_item(OP_INSERT, 7'd0, 32'sd1);

		drain_results();
		write_max_length(7'd1);
		send_item(OP_APPEND, '0, 32'sd2);
		while (list_len > 0)
			send_item(OP_DELETE, 7'd0, '0);
		send_item(OP_APPEND, '0, 32'sd42);
		send_item(OP_APPEND, '0, 32'sd43);
		send_item(OP_INSERT, 7'd0, 32'sd44);
		send_item(OP_DUMP, '0, '0);

		drain_results();
		write_max_length(7'd127);
		while (list_len < CAPACITY)
			send_item(OP_APPEND, POS_W'($urandom_range(0, 127)), $urandom);
		send_item(OP_APPEND, '0, 32'sd7);
		send_item(OP_INSERT, 7'd0, 32'sd7);
		send_item(OP_INSERT, 7'(CAPACITY), 32'sd7);
		send_item(OP_TRANSPOSE, '0, VALUE_W'(list_words[CAPACITY - 1]));
		send_item(OP_FRONT, '0, VALUE_W'(list_words[CAPACITY - 1]));
		send_item(OP_DELETE, 7'(CAPACITY - 1), '0);
		send_item(OP_INSERT, 7'(CAPACITY - 1), $urandom);
		send_item(OP_DUMP, '0, '0);
	endtask

	// Random traffic under several limits; gaps come in stretches, none in the last phase.
	task automatic test_random_traffic();
		logic [MAXLEN_W-1:0] caps [5];
		logic [OPCODE_W-1:0] op;
		logic [POS_W-1:0] pos;
		logic signed [VALUE_W-1:0] val;
		caps = '{7'd1, MAXLEN_W'($urandom_range(2, 63)), 7'd64, 7'd127,
			MAXLEN_W'($urandom_range(1, 64))};
		for (int ph = 0; ph < 5; ph++) begin
			drain_results();
			write_max_length(caps[ph]);
			for (int n = 0; n < 42; n++) begin
				if (ph < 4 && (n / 16) % 2 == 0 && $urandom_range(0, 3) == 0)
					pause_sender($urandom_range(1, 3));
				next_random_item(op, pos, val);
				send_item(op, pos, val);
			end
		end
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		start         = 1'b0;
		opcode        = '0;
		position      = '0;
		operand_value = '0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		list_len      = 0;
		len_cap       = MAXLEN_RESET;
		error_count     = 0;
		items_sent      = 0;
		results_checked = 0;
		dump_words      = 0;
		cfg_writes      = 0;
		cycle_count     = 0;

		// Hold reset, then release it away from the rising edge.
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_basic_ops();
		test_length_limit();
		test_random_traffic();

		// Wait out every owed result, then keep running to catch strays.
		drain_results();
		repeat (8) @(posedge clk);

		$display("Sent %0d transactions under %0d length limits; checked %0d results",
			items_sent, cfg_writes + 1, results_checked);
		$display("(%0d of them dumped words) in %0d cycles, %0d mismatches.",
			dump_words, cycle_count, error_count);
		if (error_count == 0 && awaited_outcomes.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
